/* rtl/core/tle_pkg.sv */
package tle_pkg;

   localparam int LINE_SIZE = 64;
   localparam int STORE_DEPTH = 64;
   localparam logic [5:0] MAX_LEN = (LINE_SIZE - 1 > 63) ? 6'd63 : 6'(LINE_SIZE - 1);

   localparam logic [7:0] CH_BS = 8'd8;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_ESC = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_TILDE = 8'd126;
   localparam logic [7:0] CH_DEL = 8'd127;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_UPPER_D = 8'h44;

   localparam logic [1:0] ESC_IDLE = 2'd0;
   localparam logic [1:0] ESC_FIRST = 2'd1;
   localparam logic [1:0] ESC_BRACKET = 2'd2;
   localparam logic [1:0] ESC_OTHER = 2'd3;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_EDIT = 3'd1;
   localparam logic [2:0] KIND_MOVE = 3'd2;
   localparam logic [2:0] KIND_BYTE = 3'd3;
   localparam logic [2:0] KIND_EMPTY = 3'd4;

   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_COMMIT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] kind;
      logic [7:0] ch;
      logic [5:0] cur_old;
      logic [5:0] len_old;
      logic [5:0] cur_new;
      logic [5:0] len_new;
   } cmd_type;

endpackage

/* rtl/core/tle_ram.sv */
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/tle_front.sv */
module tle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       rx_byte,
   output tle_pkg::cmd_type cmd
);

   logic [1:0] esc_ff, esc_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] cur_ff, cur_in;

   always_comb begin
      esc_in = esc_ff;
      cmd.op = tle_pkg::OP_REPORT;
      cmd.kind = tle_pkg::KIND_NONE;
      cmd.ch = rx_byte;
      cmd.cur_old = cur_ff;
      cmd.len_old = len_ff;
      cmd.cur_new = cur_ff;
      cmd.len_new = len_ff;
      if (esc_ff == tle_pkg::ESC_FIRST) begin
         esc_in = (rx_byte == tle_pkg::CH_LBRACKET) ? tle_pkg::ESC_BRACKET
                                                    : tle_pkg::ESC_OTHER;
      end else if (esc_ff == tle_pkg::ESC_BRACKET || esc_ff == tle_pkg::ESC_OTHER) begin
         if (esc_ff == tle_pkg::ESC_BRACKET) begin
            if (rx_byte == tle_pkg::CH_UPPER_C && cur_ff < len_ff) begin
               cmd.cur_new = cur_ff + 6'd1;
               cmd.kind = tle_pkg::KIND_MOVE;
            end else if (rx_byte == tle_pkg::CH_UPPER_D && cur_ff != 6'd0) begin
               cmd.cur_new = cur_ff - 6'd1;
               cmd.kind = tle_pkg::KIND_MOVE;
            end
         end
         esc_in = tle_pkg::ESC_IDLE;
      end else if (rx_byte inside {tle_pkg::CH_LF, tle_pkg::CH_CR}) begin
         cmd.cur_new = 6'd0;
         cmd.len_new = 6'd0;
         if (len_ff == 6'd0) begin
            cmd.kind = tle_pkg::KIND_EMPTY;
         end else begin
            cmd.op = tle_pkg::OP_COMMIT;
            cmd.kind = tle_pkg::KIND_BYTE;
         end
      end else if (rx_byte inside {tle_pkg::CH_DEL, tle_pkg::CH_BS}) begin
         if (cur_ff != 6'd0) begin
            cmd.op = tle_pkg::OP_DELETE;
            cmd.kind = tle_pkg::KIND_EDIT;
            cmd.cur_new = cur_ff - 6'd1;
            cmd.len_new = len_ff - 6'd1;
         end
      end else if (rx_byte == tle_pkg::CH_ESC) begin
         esc_in = tle_pkg::ESC_FIRST;
      end else if (rx_byte inside {[tle_pkg::CH_SPACE:tle_pkg::CH_TILDE]}) begin
         if (len_ff < tle_pkg::MAX_LEN) begin
            cmd.op = tle_pkg::OP_INSERT;
            cmd.kind = tle_pkg::KIND_EDIT;
            cmd.cur_new = cur_ff + 6'd1;
            cmd.len_new = len_ff + 6'd1;
         end
      end
      len_in = cmd.len_new;
      cur_in = cmd.cur_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= tle_pkg::ESC_IDLE;
         len_ff <= 6'd0;
         cur_ff <= 6'd0;
      end else if (push) begin
         esc_ff <= esc_in;
         len_ff <= len_in;
         cur_ff <= cur_in;
      end
   end

endmodule

/* rtl/core/tle_cmd_queue.sv */
module tle_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tle_pkg::cmd_type push_cmd,
   input  logic             pop,
   output tle_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   tle_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full = (count_ff == 2'd2);

endmodule

/* rtl/core/tle_back.sv */
module tle_back (
   input  logic             clock,
   input  logic             reset,
   input  tle_pkg::cmd_type q_head,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_line_byte,
   output logic [5:0]       rsp_cursor,
   output logic [5:0]       rsp_length,
   output logic             rsp_last
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_LAST = 3'd2;
   localparam logic [2:0] S_PUT = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_DUMP = 3'd5;

   logic [2:0]       state_ff, state_in;
   tle_pkg::cmd_type cmd_ff, cmd_in;
   logic [5:0]       rd_idx_ff, rd_idx_in;
   logic [5:0]       wr_addr_ff, wr_addr_in;
   logic             wpend_ff, wpend_in;
   logic             rpend_ff, rpend_in;
   logic             pend_last_ff, pend_last_in;
   logic             all_issued_ff, all_issued_in;

   logic             out_valid_ff, out_valid_in;
   logic [2:0]       out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [5:0]       out_cur_ff, out_cur_in;
   logic [5:0]       out_len_ff, out_len_in;
   logic             out_last_ff, out_last_in;

   logic             ram_we, ram_re;
   logic [5:0]       ram_waddr, ram_raddr;
   logic [7:0]       ram_wdata, ram_rdata;
   logic             out_free, out_load, consume, issue;

   tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      rd_idx_in = rd_idx_ff;
      wr_addr_in = wr_addr_ff;
      wpend_in = wpend_ff;
      rpend_in = rpend_ff;
      pend_last_in = pend_last_ff;
      all_issued_in = all_issued_ff;
      ram_we = 1'b0;
      ram_waddr = wr_addr_ff;
      ram_wdata = ram_rdata;
      ram_re = 1'b0;
      ram_raddr = rd_idx_ff;
      q_pop = 1'b0;
      out_load = 1'b0;
      out_kind_in = cmd_ff.kind;
      out_byte_in = 8'd0;
      out_cur_in = cmd_ff.cur_new;
      out_len_in = cmd_ff.len_new;
      out_last_in = 1'b1;
      consume = 1'b0;
      issue = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cmd_in = q_head;
               wpend_in = 1'b0;
               rpend_in = 1'b0;
               all_issued_in = 1'b0;
               case (q_head.op)
                  tle_pkg::OP_INSERT: begin
                     if (q_head.cur_old == q_head.len_old) begin
                        state_in = S_PUT;
                     end else begin
                        rd_idx_in = q_head.len_old - 6'd1;
                        state_in = S_SHIFT;
                     end
                  end
                  tle_pkg::OP_DELETE: begin
                     if (q_head.cur_old == q_head.len_old) begin
                        state_in = S_EMIT;
                     end else begin
                        rd_idx_in = q_head.cur_old;
                        state_in = S_SHIFT;
                     end
                  end
                  tle_pkg::OP_COMMIT: begin
                     rd_idx_in = 6'd0;
                     state_in = S_DUMP;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            ram_re = 1'b1;
            ram_we = wpend_ff;
            wpend_in = 1'b1;
            if (cmd_ff.op == tle_pkg::OP_INSERT) begin
               wr_addr_in = rd_idx_ff + 6'd1;
               if (rd_idx_ff == cmd_ff.cur_old) begin
                  state_in = S_LAST;
               end else begin
                  rd_idx_in = rd_idx_ff - 6'd1;
               end
            end else begin
               wr_addr_in = rd_idx_ff - 6'd1;
               if (rd_idx_ff == cmd_ff.len_old - 6'd1) begin
                  state_in = S_LAST;
               end else begin
                  rd_idx_in = rd_idx_ff + 6'd1;
               end
            end
         end
         S_LAST: begin
            ram_we = 1'b1;
            state_in = (cmd_ff.op == tle_pkg::OP_INSERT) ? S_PUT : S_EMIT;
         end
         S_PUT: begin
            ram_we = 1'b1;
            ram_waddr = cmd_ff.cur_old;
            ram_wdata = cmd_ff.ch;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            consume = rpend_ff && out_free;
            issue = !all_issued_ff && (!rpend_ff || consume);
            if (consume) begin
               out_load = 1'b1;
               out_kind_in = tle_pkg::KIND_BYTE;
               out_byte_in = ram_rdata;
               out_last_in = pend_last_ff;
               rpend_in = 1'b0;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end
            end
            if (issue) begin
               ram_re = 1'b1;
               rpend_in = 1'b1;
               pend_last_in = (rd_idx_ff == cmd_ff.len_old - 6'd1);
               all_issued_in = pend_last_in;
               rd_idx_in = rd_idx_ff + 6'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wpend_ff <= 1'b0;
         rpend_ff <= 1'b0;
         pend_last_ff <= 1'b0;
         all_issued_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wpend_ff <= wpend_in;
         rpend_ff <= rpend_in;
         pend_last_ff <= pend_last_in;
         all_issued_ff <= all_issued_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rd_idx_ff <= rd_idx_in;
      wr_addr_ff <= wr_addr_in;
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_cur_ff <= out_cur_in;
         out_len_ff <= out_len_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_line_byte = out_byte_ff;
   assign rsp_cursor = out_cur_ff;
   assign rsp_length = out_len_ff;
   assign rsp_last = out_last_ff;

endmodule

/* rtl/core/terminal_line_editor.sv */
// Keyboard line editor. Push one received byte per request; each request gives
// one response (kind 0 no change, 1 edit, 2 cursor move), except CR/LF, which
// gives one kind 3 response per line byte with last set on the final one, or
// a single kind 4 response for an empty line. Cursor and length in each response
// are the values after that byte. The front end tracks escape state, cursor and
// length and accepts a byte per cycle into a two-deep command queue while it is
// not full; the back end edits a 64-byte single-write/single-read line RAM and
// takes one command at a time. An insert steps through shift, last, put and emit
// states, or put and emit at the line end; a delete through shift, last and emit,
// or emit at the line end, the RAM moving one byte per cycle; a commit reads the
// line out as responses are popped. No clearing pass follows reset.
module terminal_line_editor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_line_byte,
   output logic [5:0] rsp_cursor,
   output logic [5:0] rsp_length,
   output logic       rsp_last
);

   tle_pkg::cmd_type front_cmd;
   tle_pkg::cmd_type q_head;
   logic             q_full, q_empty, q_pop, accept;

   assign accept = req_push && !q_full;
   assign req_full = q_full;

   tle_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .rx_byte (req_rx_byte),
      .cmd     (front_cmd)
   );

   tle_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   tle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_kind      (rsp_kind),
      .rsp_line_byte (rsp_line_byte),
      .rsp_cursor    (rsp_cursor),
      .rsp_length    (rsp_length),
      .rsp_last      (rsp_last)
   );

endmodule
